>>> hw/rtl/note_waveform_synth_assert.svh
// Assertion macros shared by the tone generator RTL.
`ifndef NOTE_WAVEFORM_SYNTH_ASSERT_SVH
`define NOTE_WAVEFORM_SYNTH_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define NWS_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication, checked out of reset.
`define NWS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

>>> hw/rtl/nws_pkg.sv
// Shared types, codes and constants of the note waveform synthesizer.
package nws_pkg;

   localparam int SINE_ADDR_BITS_DEF = 10;
   localparam int RATE_HZ_DEF        = 22050;

   typedef logic [7:0]         byte_type;
   typedef logic               op_type;
   typedef logic signed [14:0] sample_type;
   typedef logic               csr_index_type;
   typedef logic [20:0]        csr_data_type;
   typedef logic [14:0]        count_type;
   typedef logic [31:0]        phase_type;
   typedef logic [1:0]         wave_type;

   localparam op_type OP_NOTE = 1'b0;
   localparam op_type OP_TICK = 1'b1;

   localparam wave_type WAVE_SINE   = 2'd0;
   localparam wave_type WAVE_SQUARE = 2'd1;
   localparam wave_type WAVE_SAW    = 2'd2;
   localparam wave_type WAVE_NOISE  = 2'd3;

   localparam csr_index_type CSR_LIMIT = 1'b0;
   localparam csr_index_type CSR_SEED  = 1'b1;

   localparam logic [20:0] LIMIT_RESET = 21'd1323000;
   localparam logic [15:0] SEED_RESET  = 16'd44257;
   localparam logic [15:0] LFSR_TAPS   = 16'hB400;

   localparam sample_type AMP       = 15'sd16000;
   localparam count_type  COUNT_MAX = 15'h7FFF;

   localparam int PITCH_COUNT = 24;

   // Note frequency times 256, MIDI notes 48..71.
   localparam logic [16:0] FREQ_Q8 [PITCH_COUNT] = '{
      17'd33488,  17'd35479,  17'd37589,  17'd39824,  17'd42192,  17'd44701,
      17'd47359,  17'd50175,  17'd53159,  17'd56320,  17'd59669,  17'd63217,
      17'd66976,  17'd70959,  17'd75178,  17'd79649,  17'd84385,  17'd89402,
      17'd94719,  17'd100351, 17'd106318, 17'd112640, 17'd119338, 17'd126434
   };

endpackage

>>> hw/rtl/nws_if.sv
// Valid/ready channel interfaces: note/tick requests, samples, register writes.
interface nws_req_if;
   import nws_pkg::*;
   logic     valid;
   logic     ready;
   op_type   op;
   byte_type pitch_byte;
   byte_type length_byte;
   byte_type loudness_byte;
   byte_type shape_byte;

   modport source (output valid, op, pitch_byte, length_byte, loudness_byte, shape_byte,
                   input ready);
   modport sink   (input valid, op, pitch_byte, length_byte, loudness_byte, shape_byte,
                   output ready);
endinterface

interface nws_rsp_if;
   import nws_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample;
   logic       note_end;

   modport source (output valid, sample, note_end, input ready);
   modport sink   (input valid, sample, note_end, output ready);
endinterface

interface nws_csr_if;
   import nws_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   csr_data_type  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/nws_sine_rom.sv
// Full-wave sine ROM, amplitude 16000, registered read port.
module nws_sine_rom #(
   parameter int ADDR_BITS = nws_pkg::SINE_ADDR_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   rd_en,
   input  logic [ADDR_BITS-1:0]   rd_addr,
   output nws_pkg::sample_type    rd_data
);
   import nws_pkg::*;

   localparam int          DEPTH       = 1 << ADDR_BITS;
   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

   // Q30 Taylor series on the quarter wave; evaluated at elaboration only.
   function automatic sample_type sine_value(input int unsigned k);
      logic [63:0] quarter;
      logic [63:0] quad;
      logic [63:0] r;
      logic [63:0] t;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] sum;
      logic [63:0] term;
      logic [63:0] mag;
      sample_type  m15;
      quarter = 64'd1 << (ADDR_BITS - 2);
      quad    = (64'(k) >> (ADDR_BITS - 2)) & 64'd3;
      r       = 64'(k) & (quarter - 64'd1);
      t       = quad[0] ? quarter - r : r;
      x       = (t * PI_HALF_Q30) >> (ADDR_BITS - 2);
      x2      = (x * x) >> 30;
      sum     = x;
      term    = x;
      term    = ((term * x2) >> 30) / 64'd6;
      sum     = sum - term;
      term    = ((term * x2) >> 30) / 64'd20;
      sum     = sum + term;
      term    = ((term * x2) >> 30) / 64'd42;
      sum     = sum - term;
      term    = ((term * x2) >> 30) / 64'd72;
      sum     = sum + term;
      term    = ((term * x2) >> 30) / 64'd110;
      sum     = sum - term;
      term    = ((term * x2) >> 30) / 64'd156;
      sum     = sum + term;
      mag     = (sum * 64'd16000) >> 30;
      if (mag > 64'd16000) begin
         mag = 64'd16000;
      end
      m15 = 15'(mag);
      return quad[1] ? -m15 : m15;
   endfunction

   sample_type rom_table [DEPTH];
   sample_type rd_data_ff;

   for (genvar k = 0; k < DEPTH; k++) begin : g_rom
      assign rom_table[k] = sine_value(k);
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rom_table[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/note_waveform_synth.sv
// Top level of the four-waveform note tone generator.
// A note request (op 0) loads pitch, length, velocity and waveform and
// restarts the phase; a tick request (op 1) yields one sample while the note
// has samples left and the running total is below total_sample_limit, and
// nothing otherwise. One request is taken every cycle while req_bus.ready is
// high; a sample passes three stages (sine ROM read, velocity multiply,
// divide by 127 as a reciprocal multiply), which fill up while rsp is stalled,
// so req_bus.ready drops only once all of them hold a sample. No clearing
// pass after reset. Register writes are expected only while the pipe is empty.
`include "note_waveform_synth_assert.svh"

module note_waveform_synth #(
   parameter int SINE_ADDR_BITS = nws_pkg::SINE_ADDR_BITS_DEF,
   parameter int RATE_HZ        = nws_pkg::RATE_HZ_DEF
) (
   input  logic      clock,
   input  logic      reset,
   nws_req_if.sink   req_bus,
   nws_rsp_if.source rsp_bus,
   nws_csr_if.sink   csr_bus
);
   import nws_pkg::*;

   localparam logic [21:0] DIV127_RECIP = 22'd2113666;  // ceil(2^28 / 127)
   localparam int          DIV127_SHIFT = 28;

   function automatic logic [4:0] mod24(input byte_type b);
      byte_type v;
      v = b;
      if (v >= 8'd192) v = v - 8'd192;
      if (v >= 8'd96)  v = v - 8'd96;
      if (v >= 8'd48)  v = v - 8'd48;
      if (v >= 8'd24)  v = v - 8'd24;
      return v[4:0];
   endfunction

   // Constant tables built at elaboration from RATE_HZ.
   phase_type step_table  [PITCH_COUNT];
   count_type count_table [8];

   for (genvar k = 0; k < PITCH_COUNT; k++) begin : g_step
      assign step_table[k] =
         32'(((64'(FREQ_Q8[k]) << 24) + 64'(RATE_HZ / 2)) / 64'(RATE_HZ));
   end

   for (genvar k = 0; k < 8; k++) begin : g_count
      localparam int CNT = ((k + 1) * RATE_HZ) / 8;
      assign count_table[k] = (CNT > 32767) ? COUNT_MAX : 15'(CNT);
   end

   // Note state
   phase_type    phase_acc_ff,     phase_acc_in;
   phase_type    phase_step_ff,    phase_step_in;
   count_type    samples_left_ff,  samples_left_in;
   logic [20:0]  samples_total_ff, samples_total_in;
   wave_type     wave_sel_ff,      wave_sel_in;
   logic [6:0]   gain_ff,          gain_in;
   logic [15:0]  lfsr_ff,          lfsr_in;
   logic [20:0]  limit_ff,         limit_in;

   // Pipeline
   logic         s1_valid_ff, s1_valid_in;
   logic         s1_sine_ff;
   sample_type   s1_wave_ff;
   logic [6:0]   s1_gain_ff;
   logic         s1_end_ff;
   logic         s2_valid_ff, s2_valid_in;
   logic signed [21:0] s2_prod_ff;
   logic         s2_end_ff;
   logic         out_valid_ff, out_valid_in;
   sample_type   out_sample_ff;
   logic         out_end_ff;

   logic         out_load, s2_load, s1_load;
   logic         req_accept, csr_accept, can_emit, emit, note_load;
   logic         idle_tick, note_only, pipe_full;
   logic [15:0]  lfsr_next;
   logic [15:0]  noise_mod;
   logic [46:0]  saw_prod;
   logic [14:0]  saw_hi;
   sample_type   wave_in;
   sample_type   rom_data;
   sample_type   s2_wave;
   logic signed [21:0] s2_prod_full;
   logic [20:0]  div_mag;
   logic [42:0]  div_prod;
   sample_type   div_q;

   assign out_load = !out_valid_ff || rsp_bus.ready;
   assign s2_load  = !s2_valid_ff || out_load;
   assign s1_load  = !s1_valid_ff || s2_load;

   assign req_bus.ready = !reset && s1_load;
   assign csr_bus.ready = !reset;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign csr_accept    = csr_bus.valid && csr_bus.ready;

   assign can_emit  = (samples_left_ff != '0) && (samples_total_ff < limit_ff);
   assign emit      = req_accept && (req_bus.op == OP_TICK) && can_emit;
   assign note_load = req_accept && (req_bus.op == OP_NOTE);

   assign lfsr_next = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ LFSR_TAPS) : (lfsr_ff >> 1);

   // Waveform value of the emitting tick, except sine which comes from the ROM.
   always_comb begin
      noise_mod = lfsr_next;
      if (noise_mod >= 16'd64000) begin
         noise_mod = noise_mod - 16'd64000;
      end else if (noise_mod >= 16'd32000) begin
         noise_mod = noise_mod - 16'd32000;
      end
      saw_prod = 47'(phase_acc_ff) * 47'd32000;
      saw_hi   = saw_prod[46:32];
      case (wave_sel_ff)
         WAVE_SQUARE: wave_in = phase_acc_ff[31] ? -AMP : AMP;
         WAVE_SAW: begin
            // truncation toward zero rounds the negative half up
            wave_in = sample_type'(saw_hi) - AMP +
                      sample_type'((saw_hi < 15'd16000) && (saw_prod[31:0] != '0));
         end
         WAVE_NOISE:  wave_in = sample_type'(noise_mod) - AMP;
         default:     wave_in = '0;
      endcase
   end

   always_comb begin
      phase_acc_in     = phase_acc_ff;
      phase_step_in    = phase_step_ff;
      samples_left_in  = samples_left_ff;
      samples_total_in = samples_total_ff;
      wave_sel_in      = wave_sel_ff;
      gain_in          = gain_ff;
      lfsr_in          = lfsr_ff;
      limit_in         = limit_ff;
      if (note_load) begin
         phase_step_in   = step_table[mod24(req_bus.pitch_byte)];
         phase_acc_in    = '0;
         samples_left_in = count_table[req_bus.length_byte[2:0]];
         gain_in         = {1'b0, req_bus.loudness_byte[5:0]} + 7'd32;
         wave_sel_in     = req_bus.shape_byte[1:0];
      end else if (emit) begin
         phase_acc_in     = phase_acc_ff + phase_step_ff;
         samples_left_in  = samples_left_ff - 15'd1;
         samples_total_in = samples_total_ff + 21'd1;
         if (wave_sel_ff == WAVE_NOISE) begin
            lfsr_in = lfsr_next;
         end
      end
      if (csr_accept) begin
         unique case (csr_bus.index)
            CSR_LIMIT: limit_in = csr_bus.data;
            CSR_SEED:  lfsr_in  = csr_bus.data[15:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff     <= '0;
         phase_step_ff    <= '0;
         samples_left_ff  <= '0;
         samples_total_ff <= '0;
         wave_sel_ff      <= WAVE_SINE;
         gain_ff          <= '0;
         lfsr_ff          <= SEED_RESET;
         limit_ff         <= LIMIT_RESET;
      end else begin
         phase_acc_ff     <= phase_acc_in;
         phase_step_ff    <= phase_step_in;
         samples_left_ff  <= samples_left_in;
         samples_total_ff <= samples_total_in;
         wave_sel_ff      <= wave_sel_in;
         gain_ff          <= gain_in;
         lfsr_ff          <= lfsr_in;
         limit_ff         <= limit_in;
      end
   end

   nws_sine_rom #(
      .ADDR_BITS (SINE_ADDR_BITS)
   ) u_sine_rom (
      .clock   (clock),
      .rd_en   (s1_load),
      .rd_addr (phase_acc_ff[31 -: SINE_ADDR_BITS]),
      .rd_data (rom_data)
   );

   // Stage 2: velocity multiply; stage 3: divide by 127 toward zero.
   assign s2_wave      = s1_sine_ff ? rom_data : s1_wave_ff;
   assign s2_prod_full = s2_wave * $signed({1'b0, s1_gain_ff});
   assign div_mag      = s2_prod_ff[21] ? 21'(-s2_prod_ff) : s2_prod_ff[20:0];
   assign div_prod     = 43'(div_mag) * 43'(DIV127_RECIP);
   assign div_q        = sample_type'(div_prod >> DIV127_SHIFT);

   assign s1_valid_in  = s1_load ? emit : s1_valid_ff;
   assign s2_valid_in  = s2_load ? s1_valid_ff : s2_valid_ff;
   assign out_valid_in = out_load ? s2_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_sine_ff <= (wave_sel_ff == WAVE_SINE);
         s1_wave_ff <= wave_in;
         s1_gain_ff <= gain_ff;
         s1_end_ff  <= (samples_left_ff == 15'd1);
      end
      if (s2_load) begin
         s2_prod_ff <= s2_prod_full;
         s2_end_ff  <= s1_end_ff;
      end
      if (out_load) begin
         out_sample_ff <= s2_prod_ff[21] ? -div_q : div_q;
         out_end_ff    <= s2_end_ff;
      end
   end

   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.sample   = out_sample_ff;
   assign rsp_bus.note_end = out_end_ff;

   assign idle_tick = req_accept && (req_bus.op == OP_TICK) && !can_emit && !csr_accept;
   assign note_only = note_load && !csr_accept;
   assign pipe_full = s1_valid_ff && s2_valid_ff && out_valid_ff;

   `NWS_ASSERT_NEXT(a_idle_tick_holds, clock, reset, idle_tick, $stable({samples_total_ff, phase_acc_ff}))
   `NWS_ASSERT_NEXT(a_note_restarts, clock, reset, note_only, samples_left_ff != '0 && phase_acc_ff == '0)
   `NWS_ASSERT_IMPL(a_full_stall, clock, reset, pipe_full && !rsp_bus.ready, !req_bus.ready)

endmodule
